FILE: src/srts_pkg.sv
// Shared types and constants for the shortest-remaining-time scheduler.
// Used by the channel interfaces, the controller, the datapath and the top level.
package srts_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int SLOT_W    = 4;
	localparam int ID_W      = 8;
	localparam int TVAL_W    = 16;
	localparam int TIME_W    = 21;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// One stored process slot
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TVAL_W-1:0] arrival;
		logic [TVAL_W-1:0] burst;
		logic [TVAL_W-1:0] remaining;
	} entry_t;

	// Request item
	typedef struct packed {
		logic              req_type;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   proc_id;
		logic [TVAL_W-1:0] arrival;
		logic [TVAL_W-1:0] burst;
	} req_t;

	// Result item
	typedef struct packed {
		logic              ran;
		logic [ID_W-1:0]   run_id;
		logic              finished;
		logic [TIME_W-1:0] finish_time;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_COMMIT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic latch;
		logic rd_en;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_last;
		logic out_busy;
	} dp_stat_t;

endpackage

FILE: src/srts_chan_if.sv
// Valid/ready channels for request and result items.
// Depends on srts_pkg for field widths.
interface srts_req_if import srts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [SLOT_W-1:0] slot;
	logic [ID_W-1:0]   proc_id;
	logic [TVAL_W-1:0] arrival;
	logic [TVAL_W-1:0] burst;

	modport source (output valid, req_type, slot, proc_id, arrival, burst, input ready);
	modport sink   (input valid, req_type, slot, proc_id, arrival, burst, output ready);
endinterface

interface srts_rsp_if import srts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              ran;
	logic [ID_W-1:0]   run_id;
	logic              finished;
	logic [TIME_W-1:0] finish_time;
	logic [TIME_W-1:0] turnaround;
	logic [TIME_W-1:0] waiting;

	modport source (output valid, ran, run_id, finished, finish_time, turnaround, waiting,
		input ready);
	modport sink   (input valid, ran, run_id, finished, finish_time, turnaround, waiting,
		output ready);
endinterface

FILE: src/srts_ctrl.sv
// Sequencing state machine of the scheduler: accept, scan, commit.
// Depends on srts_pkg for the state enum and the command/status structs.
module srts_ctrl import srts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_req_type,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (in_req_type == REQ_TICK) ? ST_SCAN : ST_COMMIT;
				end
			end
			ST_SCAN: begin
				if (stat.scan_last) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!stat.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
			end
			ST_LAST: begin
				cmd = '0;
			end
			ST_COMMIT: begin
				cmd.commit = !stat.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: src/srts_dp.sv
// Datapath of the scheduler: slot table memory, valid bits, scan compare,
// time counter and result register. Depends on srts_pkg.
module srts_dp import srts_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_cmd_t cmd,
	output dp_stat_t  stat,
	input  req_t      req_in,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_t      rsp_out
);

	localparam int IDX_W = $clog2(SLOTS);

	entry_t            mem [SLOTS];
	logic [SLOTS-1:0]  valid_q;

	req_t              req_q;
	logic [TIME_W-1:0] now_q;
	logic [IDX_W-1:0]  scan_cnt_q;

	logic              rd_valid_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	entry_t            rd_entry_s1;

	logic              best_found_q;
	logic [IDX_W-1:0]  best_idx_q;
	entry_t            best_q;

	logic              out_valid_q;
	rsp_t              out_q;

	logic              eligible;
	logic              better;
	logic              slot_ok;
	logic [IDX_W-1:0]  load_idx;
	logic [TIME_W-1:0] now_next;
	logic [TVAL_W-1:0] rem_dec;
	logic              fin;
	logic [TIME_W-1:0] tat;
	logic [TIME_W-1:0] burst_ext;
	logic [TIME_W-1:0] wt;
	rsp_t              rsp_d;

	assign stat.scan_last = (scan_cnt_q == IDX_W'(SLOTS - 1));
	assign stat.out_busy  = out_valid_q && !rsp_ready;

	// Latch the accepted item
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_in;
		end
	end

	// Scan counter: one table read per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q  <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			if (cmd.latch) begin
				scan_cnt_q <= '0;
			end else if (cmd.rd_en && !stat.scan_last) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
		end
	end

	// Load address check and index
	assign slot_ok  = (32'(req_q.slot) < SLOTS);
	assign load_idx = IDX_W'(req_q.slot);

	// Table memory: registered read, single write on commit
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_entry_s1 <= mem[scan_cnt_q];
			rd_idx_s1   <= scan_cnt_q;
		end
		if (cmd.commit) begin
			if (req_q.req_type == REQ_LOAD) begin
				if (slot_ok) begin
					mem[load_idx] <= '{id: req_q.proc_id, arrival: req_q.arrival,
						burst: req_q.burst, remaining: req_q.burst};
				end
			end else if (best_found_q) begin
				mem[best_idx_q] <= '{id: best_q.id, arrival: best_q.arrival,
					burst: best_q.burst, remaining: rem_dec};
			end
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit && req_q.req_type == REQ_LOAD && slot_ok) begin
			valid_q[load_idx] <= (req_q.burst != '0);
		end
	end

	// Compare the read slot against the best so far
	assign eligible = valid_q[rd_idx_s1] && (rd_entry_s1.remaining != '0) &&
		(TIME_W'(rd_entry_s1.arrival) <= now_q);
	assign better = !best_found_q || (rd_entry_s1.remaining < best_q.remaining) ||
		((rd_entry_s1.remaining == best_q.remaining) &&
		 (rd_entry_s1.arrival < best_q.arrival));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_found_q <= 1'b0;
		end else if (cmd.latch) begin
			best_found_q <= 1'b0;
		end else if (rd_valid_s1 && eligible && better) begin
			best_found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1 && eligible && better) begin
			best_q     <= rd_entry_s1;
			best_idx_q <= rd_idx_s1;
		end
	end

	// Result of the committed item
	assign now_next  = (now_q == TIME_MAX) ? now_q : now_q + 1'b1;
	assign rem_dec   = best_q.remaining - 1'b1;
	assign fin       = best_found_q && (rem_dec == '0);
	assign tat       = now_next - TIME_W'(best_q.arrival);
	assign burst_ext = TIME_W'(best_q.burst);
	assign wt        = (tat >= burst_ext) ? tat - burst_ext : '0;

	always_comb begin
		rsp_d = '0;
		if (req_q.req_type == REQ_LOAD) begin
			rsp_d.finish_time = now_q;
		end else begin
			rsp_d.finish_time = now_next;
			rsp_d.ran         = best_found_q;
			rsp_d.run_id      = best_found_q ? best_q.id : '0;
			rsp_d.finished    = fin;
			rsp_d.turnaround  = fin ? tat : '0;
			rsp_d.waiting     = fin ? wt : '0;
		end
	end

	// Advance time on a committed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
		end else if (cmd.commit && req_q.req_type == REQ_TICK) begin
			now_q <= now_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q <= rsp_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_out   = out_q;

endmodule

FILE: src/shortest_remaining_time_scheduler_top.sv
// Preemptive shortest-remaining-time-first scheduler. A load item writes one
// process slot; a tick item runs the eligible slot with the least remaining
// time (ties: earlier arrival, then lower slot) for one tick and returns one
// result item. A tick scans every slot before the next item can be accepted:
// the scan reads one slot per cycle through the table memory's single read
// port, then a compare state and a commit state follow. A load item goes
// straight from acceptance to the commit state. The result waits in an
// output register; a commit stalls only while that register is still full.
// Depends on srts_pkg, srts_chan_if, srts_ctrl and srts_dp.
module shortest_remaining_time_scheduler_top import srts_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	srts_req_if.sink    req,
	srts_rsp_if.source  rsp
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	req_t      req_in;
	rsp_t      rsp_out;

	// Pack the request channel
	assign req_in = '{req_type: req.req_type, slot: req.slot, proc_id: req.proc_id,
		arrival: req.arrival, burst: req.burst};

	srts_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_req_type (req.req_type),
		.in_ready    (req.ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	srts_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req_in    (req_in),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_out   (rsp_out)
	);

	// Unpack the result channel
	assign rsp.ran         = rsp_out.ran;
	assign rsp.run_id      = rsp_out.run_id;
	assign rsp.finished    = rsp_out.finished;
	assign rsp.finish_time = rsp_out.finish_time;
	assign rsp.turnaround  = rsp_out.turnaround;
	assign rsp.waiting     = rsp_out.waiting;

	// Busy right after an item is accepted
	assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("scheduler ready right after accepting an item");

	// A finished process must have run
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.finished |-> rsp.ran)
		else $error("finished without ran");

	// Waiting never exceeds turnaround
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.finished |-> rsp.waiting <= rsp.turnaround)
		else $error("waiting larger than turnaround");

	// Commit never fires while the output register is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(rsp.valid && !rsp.ready))
		else $error("result overwritten while stalled");

endmodule

FILE: test/tb_shortest_remaining_time_scheduler_top.sv
// Self-checking testbench for shortest_remaining_time_scheduler_top: random and directed
// load/tick items, cycle-free prediction of every result, field-by-field comparison.
// Depends on srts_pkg, srts_chan_if and the scheduler RTL.
`timescale 1ns / 1ps

module tb_shortest_remaining_time_scheduler_top import srts_pkg::*; ();

	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;

	srts_req_if req_ch ();
	srts_rsp_if rsp_ch ();

	shortest_remaining_time_scheduler_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Scheduler state as seen by the predictor
	logic              sched_valid   [SLOTS_DEF];
	logic [TVAL_W-1:0] sched_arrival [SLOTS_DEF];
	logic [TVAL_W-1:0] sched_burst   [SLOTS_DEF];
	logic [TVAL_W-1:0] sched_left    [SLOTS_DEF];
	logic [ID_W-1:0]   sched_id      [SLOTS_DEF];
	logic [TIME_W-1:0] sched_now;

	req_t pending_reqs[$];
	rsp_t expected_results[$];

	int  mismatch_count = 0;
	int  items_queued   = 0;
	int  gen_time       = 0;
	int  send_idle_pct  = 0;
	int  recv_idle_pct  = 0;
	bit  hold_go        = 1'b0;
	bit  hold_done      = 1'b0;
	logic recv_hold     = 1'b0;

	always #1 clk = ~clk;

	// Apply one item to the scheduler state and return the result it causes
	function automatic rsp_t schedule_step(input req_t item);
		int          best;
		logic [31:0] tat;
		logic [31:0] wt;
		rsp_t        res;
		res = '0;
		best = -1;
		if (item.req_type == REQ_LOAD) begin
			if (int'(item.slot) < SLOTS_DEF) begin
				sched_valid[item.slot]   = (item.burst != '0);
				sched_id[item.slot]      = item.proc_id;
				sched_arrival[item.slot] = item.arrival;
				sched_burst[item.slot]   = item.burst;
				sched_left[item.slot]    = item.burst;
			end
			res.finish_time = sched_now;
			return res;
		end
		// pick least remaining, then earliest arrival, then lowest slot
		for (int i = 0; i < SLOTS_DEF; i++) begin
			if (!sched_valid[i] || sched_left[i] == '0 || TIME_W'(sched_arrival[i]) > sched_now)
				continue;
			if (best < 0 || sched_left[i] < sched_left[best] ||
				(sched_left[i] == sched_left[best] && sched_arrival[i] < sched_arrival[best]))
				best = i;
		end
		if (sched_now != TIME_MAX)
			sched_now = sched_now + 1'b1;
		res.finish_time = sched_now;
		if (best >= 0) begin
			sched_left[best] = sched_left[best] - 1'b1;
			res.ran = 1'b1;
			res.run_id = sched_id[best];
			if (sched_left[best] == '0) begin
				tat = 32'(sched_now) - 32'(sched_arrival[best]);
				wt = (tat >= 32'(sched_burst[best])) ? tat - 32'(sched_burst[best]) : 32'd0;
				res.finished = 1'b1;
				res.turnaround = tat[TIME_W-1:0];
				res.waiting = wt[TIME_W-1:0];
			end
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic [TIME_W-1:0] want,
		input logic [TIME_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Request driver: predict on acceptance, then offer the next queued item
	always @(posedge clk or negedge arst_n) begin : req_driver
		req_t cur;
		req_t nxt;
		if (!arst_n) begin
			req_ch.valid    <= 1'b0;
			req_ch.req_type <= REQ_LOAD;
			req_ch.slot     <= '0;
			req_ch.proc_id  <= '0;
			req_ch.arrival  <= '0;
			req_ch.burst    <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				cur.req_type = req_ch.req_type;
				cur.slot     = req_ch.slot;
				cur.proc_id  = req_ch.proc_id;
				cur.arrival  = req_ch.arrival;
				cur.burst    = req_ch.burst;
				expected_results.push_back(schedule_step(cur));
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = pending_reqs.pop_front();
					req_ch.valid    <= 1'b1;
					req_ch.req_type <= nxt.req_type;
					req_ch.slot     <= nxt.slot;
					req_ch.proc_id  <= nxt.proc_id;
					req_ch.arrival  <= nxt.arrival;
					req_ch.burst    <= nxt.burst;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each accepted item with the oldest expectation
	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		rsp_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result expected none, got ran=%0d id=%0d fin=%0d t=%0d",
						$time, rsp_ch.ran, rsp_ch.run_id, rsp_ch.finished, rsp_ch.finish_time);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("ran", TIME_W'(want.ran), TIME_W'(rsp_ch.ran));
					check_field("run_id", TIME_W'(want.run_id), TIME_W'(rsp_ch.run_id));
					check_field("finished", TIME_W'(want.finished), TIME_W'(rsp_ch.finished));
					check_field("finish_time", want.finish_time, rsp_ch.finish_time);
					check_field("turnaround", want.turnaround, rsp_ch.turnaround);
					check_field("waiting", want.waiting, rsp_ch.waiting);
				end
			end
			rsp_ch.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Long receiver hold-off so the result register fills and the input stalls
	initial begin : recv_holdoff
		wait (hold_go);
		@(posedge clk);
		recv_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		recv_hold <= 1'b0;
		hold_done = 1'b1;
	end

	task automatic push_load(input logic [SLOT_W-1:0] s, input logic [ID_W-1:0] id,
		input logic [TVAL_W-1:0] arr, input logic [TVAL_W-1:0] bst);
		req_t item;
		item.req_type = REQ_LOAD;
		item.slot     = s;
		item.proc_id  = id;
		item.arrival  = arr;
		item.burst    = bst;
		pending_reqs.push_back(item);
		items_queued++;
	endtask

	// Tick items carry random payload, which the block must ignore
	task automatic push_ticks(input int n);
		req_t item;
		for (int i = 0; i < n; i++) begin
			item.req_type = REQ_TICK;
			item.slot     = SLOT_W'($urandom);
			item.proc_id  = ID_W'($urandom);
			item.arrival  = TVAL_W'($urandom);
			item.burst    = TVAL_W'($urandom);
			pending_reqs.push_back(item);
			items_queued++;
			gen_time++;
		end
	endtask

	function automatic logic [TVAL_W-1:0] near_arrival();
		int a;
		a = gen_time + $urandom_range(0, 3);
		return (a > 65535) ? 16'hFFFF : TVAL_W'(a);
	endfunction

	// Mostly well-formed job sets with enough ticks to finish them; some noise
	task automatic random_batch(input int n_items);
		int start;
		int k;
		int work;
		int extra;
		int b;
		int r;
		start = items_queued;
		while (items_queued - start < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				k = $urandom_range(1, 4);
				work = 0;
				for (int j = 0; j < k; j++) begin
					b = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
					work += b;
					push_load(SLOT_W'($urandom), ID_W'($urandom), near_arrival(), TVAL_W'(b));
				end
				extra = $urandom_range(0, 3);
				for (int j = 0; j < work + extra; j++) begin
					// preempt now and then with a fresh short job
					if ($urandom_range(0, 99) < 10) begin
						b = $urandom_range(1, 4);
						work += b;
						push_load(SLOT_W'($urandom), ID_W'($urandom), near_arrival(),
							TVAL_W'(b));
					end
					push_ticks(1);
				end
			end else if (r < 85) begin
				push_load(SLOT_W'($urandom), ID_W'($urandom), TVAL_W'($urandom), '0);
			end else if (r < 93) begin
				push_load(SLOT_W'($urandom), ID_W'($urandom), TVAL_W'($urandom),
					TVAL_W'($urandom));
			end else begin
				push_ticks($urandom_range(1, 3));
			end
		end
	endtask

	// Hold the sender until every expected result has come back
	task automatic drain();
		while (pending_reqs.size() != 0 || req_ch.valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		for (int i = 0; i < SLOTS_DEF; i++) begin
			sched_valid[i]   = 1'b0;
			sched_arrival[i] = '0;
			sched_burst[i]   = '0;
			sched_left[i]    = '0;
			sched_id[i]      = '0;
		end
		sched_now = '0;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: idle tick, tie breaks, far arrival, zero burst, reload, clear
		push_ticks(1);
		push_load(4'd0, 8'hFF, 16'd1, 16'd3);
		push_load(4'd15, 8'h00, 16'd0, 16'd2);
		push_load(4'd9, 8'h5A, 16'd1, 16'd2);
		push_load(4'd3, 8'hC3, 16'd1, 16'd2);
		push_load(4'd7, 8'h77, 16'hFFFF, 16'hFFFF);
		push_load(4'd12, 8'h12, 16'd0, 16'd0);
		push_ticks(3);
		push_load(4'd3, 8'h33, 16'd2, 16'd1);
		push_load(4'd0, 8'hFF, 16'd1, 16'd0);
		push_ticks(4);
		push_load(4'd10, 8'h80, 16'd0, 16'hFFFF);
		push_ticks(2);
		push_load(4'd10, 8'h80, 16'd0, 16'd0);
		push_load(4'd7, 8'h77, 16'hFFFF, 16'd0);
		drain();

		// Random phases with different idling on each side
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_batch(190);
		drain();
		send_idle_pct = 48;
		random_batch(190);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 48;
		random_batch(190);
		drain();

		// Back-pressure: keep offering items while the receiver holds off
		recv_idle_pct = 0;
		hold_go = 1'b1;
		random_batch(40);
		wait (hold_done);
		drain();

		send_idle_pct = 19;
		recv_idle_pct = 19;
		random_batch(190);
		drain();

		repeat (SLOTS_DEF + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
